// File: rtl/core/mec_pkg.sv
// Shared types, fixed-point constants and helpers for the escape-time core.
package mec_pkg;

  // Q4.28 signed arithmetic; the step registers use the same 28-bit grid
  localparam int FRAC_BITS = 28;
  localparam int STEP_FRAC = 28;
  localparam int QW        = FRAC_BITS + 4;
  localparam int SW        = QW + 4;
  localparam int PW        = 2 * QW;

  localparam int IDX_W     = 12;
  localparam int ITER_W    = 25;
  localparam int STEP_W    = 30;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [QW-1:0]  q_t;
  typedef logic signed [SW-1:0]  wide_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic [ITER_W-1:0]     iter_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_MAX_ITER = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_STEP_X   = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_STEP_Y   = cfg_idx_t'(2);

  localparam iter_t MAX_ITER_RST = iter_t'(524288);
  localparam step_t STEP_RST     = step_t'(1008054);

  localparam longint ONE_L = longint'(1) << FRAC_BITS;

  localparam q_t Q_MAX     = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN     = {1'b1, {(QW-1){1'b0}}};
  localparam q_t Q_ONE     = q_t'(ONE_L);
  localparam q_t Q_QUARTER = q_t'(ONE_L >>> 2);
  localparam q_t Q_HALF    = q_t'(ONE_L >>> 1);
  localparam q_t Q_NEG_3Q  = q_t'(-((3 * ONE_L) >>> 2));
  localparam q_t Q_R16     = q_t'(ONE_L >>> 4);
  localparam q_t Q_LIMIT4  = q_t'(ONE_L <<< 2);
  localparam q_t Q_OFF_RE  = q_t'(-2 * ONE_L);
  localparam q_t Q_OFF_IM  = q_t'(-((9 * ONE_L) >>> 3));

  // index*step is clamped to 16.0
  localparam prod_t P_CAP = prod_t'(longint'(16) << STEP_FRAC);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COORD_MUL,
    S_COORD_ADD,
    S_OFFSETS,
    S_PRE_MUL,
    S_PRE_SUM,
    S_CARD_Q,
    S_CARD_QX,
    S_CARD_MUL,
    S_CARD_CMP,
    S_IT_MUL,
    S_IT_ADD
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_COORD_MUL,
    OP_COORD_ADD,
    OP_OFFSETS,
    OP_PRE_MUL,
    OP_PRE_SUM,
    OP_CARD_Q,
    OP_CARD_QX,
    OP_CARD_MUL,
    OP_CARD_CMP,
    OP_IT_MUL,
    OP_IT_ADD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic caught;
    logic escaped;
  } dp_status_t;

  function automatic wide_t sx(input q_t x);
    return {{(SW-QW){x[QW-1]}}, x};
  endfunction

  function automatic q_t sat_q(input wide_t v);
    logic [SW-QW:0] hi_bits;
    q_t             res;
    hi_bits = v[SW-1:QW-1];
    if ((hi_bits == '0) || (hi_bits == '1)) begin
      res = v[QW-1:0];
    end else if (v[SW-1]) begin
      res = Q_MIN;
    end else begin
      res = Q_MAX;
    end
    return res;
  endfunction

  // floor(a*b / 2^F), saturated
  function automatic q_t mul_q(input prod_t p);
    prod_t sh;
    sh = p >>> FRAC_BITS;
    return sat_q(sh[SW-1:0]);
  endfunction

endpackage

// File: rtl/core/mandelbrot_escape_iterations_core.sv
// Top level: config registers, controller and datapath of the Mandelbrot escape-time core.
// From the start beat the sequencer loads the pixel, forms the coordinates, runs the disc and
// cardioid pre-checks, then iterates until escape or the limit; the result strobe is registered.
// One pixel at a time; each iteration has a multiply state, then an add/compare state.
// busy drops with the result strobe, so the next start is taken in that same cycle.
// rst_n is synchronous: clears the sequencer and loads the register reset values.
module mandelbrot_escape_iterations_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mec_pkg::IDX_W-1:0]      in_column,
  input  logic [mec_pkg::IDX_W-1:0]      in_row,
  output logic                           out_valid,
  output logic [mec_pkg::ITER_W-1:0]     out_iteration_count,
  input  logic                           cfg_we,
  input  logic [mec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mec_pkg::CFG_W-1:0]      cfg_wdata
);
  import mec_pkg::*;

  // coordinates are masked to COORD_BITS; the ports carry at most IDX_W bits
  localparam int CW = (COORD_BITS < IDX_W) ? COORD_BITS : IDX_W;

  iter_t      max_iter_r;
  step_t      step_x_r, step_y_r;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      step_x_r   <= STEP_RST;
      step_y_r   <= STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ITER: max_iter_r <= cfg_wdata[ITER_W-1:0];
        CFG_STEP_X:   step_x_r   <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_Y:   step_y_r   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .max_iter  (max_iter_r),
    .status    (status),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_count (out_iteration_count)
  );

  mec_datapath #(
    .CW (CW)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .column (in_column[CW-1:0]),
    .row    (in_row[CW-1:0]),
    .step_x (step_x_r),
    .step_y (step_y_r),
    .status (status)
  );

endmodule

// File: rtl/core/mec_datapath.sv
// Datapath: three registered multipliers, pre-checks and the z = z*z + c step.
module mec_datapath #(
  parameter int CW = 12
) (
  input  logic                clk,
  input  mec_pkg::dp_cmd_t    cmd,
  input  logic [CW-1:0]       column,
  input  logic [CW-1:0]       row,
  input  mec_pkg::step_t      step_x,
  input  mec_pkg::step_t      step_y,
  output mec_pkg::dp_status_t status
);
  import mec_pkg::*;

  logic [CW-1:0] col_r, row_r;
  prod_t prod0_r, prod1_r, prod2_r;
  q_t cr_r, ci_r, s_r, xs_r, yy_r, q_r, qx_r, zr_r, zi_r;
  logic win_r, disc_r;

  q_t m0a, m0b, m1a, m1b, m2a, m2b;
  q_t a, b, m;
  prod_t pc0, pc1;
  q_t cr_c, ci_c, nr_c, ni_c;
  logic disc_c;

  always_comb begin
    m0a = '0; m0b = '0;
    m1a = '0; m1b = '0;
    m2a = '0; m2b = '0;
    unique case (cmd.op)
      OP_COORD_MUL: begin
        m0a = q_t'(col_r); m0b = q_t'(step_x);
        m1a = q_t'(row_r); m1b = q_t'(step_y);
      end
      OP_PRE_MUL: begin
        m0a = cr_r; m0b = cr_r;
        m1a = ci_r; m1b = ci_r;
        m2a = s_r;  m2b = s_r;
      end
      OP_PRE_SUM: begin
        m0a = xs_r; m0b = xs_r;
      end
      OP_CARD_MUL: begin
        m0a = q_r; m0b = qx_r;
      end
      OP_IT_MUL: begin
        m0a = zr_r; m0b = zr_r;
        m1a = zi_r; m1b = zi_r;
        m2a = zr_r; m2b = zi_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod0_r <= m0a * m0b;
    prod1_r <= m1a * m1b;
    prod2_r <= m2a * m2b;
  end

  assign a = mul_q(prod0_r);
  assign b = mul_q(prod1_r);
  assign m = mul_q(prod2_r);

  // coordinates: clamp index*step, grids match so no rescale
  assign pc0  = (prod0_r > P_CAP) ? P_CAP : prod0_r;
  assign pc1  = (prod1_r > P_CAP) ? P_CAP : prod1_r;
  assign cr_c = sat_q(wide_t'(pc0[SW-1:0]) + sx(Q_OFF_RE));
  assign ci_c = sat_q(wide_t'(pc1[SW-1:0]) + sx(Q_OFF_IM));

  // discs of radius 1/4 around 0 and -1; b is Im(c)^2 here
  assign disc_c = ((sx(a) + sx(b)) < sx(Q_R16)) || ((sx(m) + sx(b)) < sx(Q_R16));

  assign nr_c = sat_q(sx(a) - sx(b) + sx(cr_r));
  assign ni_c = sat_q((sx(m) <<< 1) + sx(ci_r));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        col_r <= column;
        row_r <= row;
      end
      OP_COORD_ADD: begin
        cr_r <= cr_c;
        ci_r <= ci_c;
      end
      OP_OFFSETS: begin
        s_r   <= sat_q(sx(cr_r) + sx(Q_ONE));
        xs_r  <= sat_q(sx(cr_r) - sx(Q_QUARTER));
        win_r <= (cr_r > Q_NEG_3Q) && (cr_r < Q_HALF);
      end
      OP_PRE_SUM: begin
        yy_r   <= b;
        disc_r <= disc_c;
      end
      OP_CARD_Q:  q_r  <= sat_q(sx(a) + sx(yy_r));
      OP_CARD_QX: qx_r <= sat_q(sx(q_r) + sx(xs_r));
      OP_CARD_CMP: begin
        zr_r <= '0;
        zi_r <= '0;
      end
      OP_IT_ADD: begin
        zr_r <= nr_c;
        zi_r <= ni_c;
      end
      default: ;
    endcase
  end

  // caught is read during the cardioid compare, escaped during an iteration add
  assign status.caught  = disc_r || (win_r && (a < (yy_r >>> 2)));
  assign status.escaped = (sx(a) + sx(b)) >= sx(Q_LIMIT4);

endmodule

// File: rtl/core/mec_ctrl.sv
// Controller: sequences pre-checks and iterations, counts and registers the result.
module mec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mec_pkg::iter_t      max_iter,
  input  mec_pkg::dp_status_t status,
  output mec_pkg::dp_cmd_t    cmd,
  output logic                out_valid,
  output mec_pkg::iter_t      out_count
);
  import mec_pkg::*;

  ctl_state_t state_r, state_nxt;
  iter_t      n_r, n_nxt;
  iter_t      n_inc;
  logic       out_valid_r, out_valid_nxt;
  iter_t      out_count_r, out_count_nxt;
  logic       last_iter;

  assign n_inc     = n_r + iter_t'(1);
  assign last_iter = (n_inc == max_iter);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (start) state_nxt = S_COORD_MUL;
      S_COORD_MUL: state_nxt = S_COORD_ADD;
      S_COORD_ADD: state_nxt = S_OFFSETS;
      S_OFFSETS:   state_nxt = S_PRE_MUL;
      S_PRE_MUL:   state_nxt = S_PRE_SUM;
      S_PRE_SUM:   state_nxt = S_CARD_Q;
      S_CARD_Q:    state_nxt = S_CARD_QX;
      S_CARD_QX:   state_nxt = S_CARD_MUL;
      S_CARD_MUL:  state_nxt = S_CARD_CMP;
      S_CARD_CMP: begin
        if (status.caught || (max_iter == '0)) state_nxt = S_IDLE;
        else                                   state_nxt = S_IT_MUL;
      end
      S_IT_MUL:    state_nxt = S_IT_ADD;
      S_IT_ADD: begin
        if (status.escaped || last_iter) state_nxt = S_IDLE;
        else                             state_nxt = S_IT_MUL;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NONE;
    n_nxt         = n_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    unique case (state_r)
      S_IDLE:      if (start) cmd.op = OP_LOAD;
      S_COORD_MUL: cmd.op = OP_COORD_MUL;
      S_COORD_ADD: cmd.op = OP_COORD_ADD;
      S_OFFSETS:   cmd.op = OP_OFFSETS;
      S_PRE_MUL:   cmd.op = OP_PRE_MUL;
      S_PRE_SUM:   cmd.op = OP_PRE_SUM;
      S_CARD_Q:    cmd.op = OP_CARD_Q;
      S_CARD_QX:   cmd.op = OP_CARD_QX;
      S_CARD_MUL:  cmd.op = OP_CARD_MUL;
      S_CARD_CMP: begin
        cmd.op = OP_CARD_CMP;
        n_nxt  = '0;
        if (status.caught) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = max_iter;
        end else if (max_iter == '0) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = '0;
        end
      end
      S_IT_MUL:    cmd.op = OP_IT_MUL;
      S_IT_ADD: begin
        cmd.op = OP_IT_ADD;
        n_nxt  = n_inc;
        if (status.escaped) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = n_r;
        end else if (last_iter) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = n_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result beat while still working");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_CARD_CMP || $past(state_r) == S_IT_ADD))
    else $error("result beat from a non-deciding state");
`endif

endmodule

// File: sim/mandelbrot_escape_iterations_checker.sv
`timescale 1ns / 100ps
// Checker for the escape-time core: tracks the registers, predicts each pixel's count, compares.
module mandelbrot_escape_iterations_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [mec_pkg::IDX_W-1:0]           in_column,
  input  logic [mec_pkg::IDX_W-1:0]           in_row,
  input  logic                                out_valid,
  input  logic [mec_pkg::ITER_W-1:0]          out_iteration_count,
  input  logic                                cfg_we,
  input  logic [mec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mec_pkg::CFG_W-1:0]           cfg_wdata,
  output int                                  error_count,
  output int                                  pending_count,
  output int                                  checked_count,
  output int                                  held_count
);

  // Q4.28 signed values carried in longint; steps sit on the same 28-bit grid
  localparam int     FRAC      = mec_pkg::FRAC_BITS;
  localparam longint UNIT      = 64'sd1 <<< FRAC;
  localparam longint Q_HI      = (64'sd1 <<< (FRAC + 3)) - 1;
  localparam longint Q_LO      = -(64'sd1 <<< (FRAC + 3));
  localparam longint COORD_CAP = 64'sd16 <<< FRAC;
  localparam longint RE_ORIGIN = -2 * UNIT;
  localparam longint IM_ORIGIN = -((9 * UNIT) >>> 3);
  localparam longint DISC_R2   = UNIT >>> 4;
  localparam longint ESCAPE_R2 = UNIT <<< 2;

  typedef struct packed {
    logic [mec_pkg::IDX_W-1:0] col;
    logic [mec_pkg::IDX_W-1:0] row;
    mec_pkg::iter_t            count;
  } pixel_count_t;

  mec_pkg::iter_t max_iter_cfg;
  mec_pkg::step_t step_re_cfg;
  mec_pkg::step_t step_im_cfg;
  pixel_count_t   expected_counts[$];

  function automatic longint q_sat(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // floor of the exact product, then clipped
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return q_sat(p >>> FRAC);
  endfunction

  function automatic longint pixel_coord(input longint idx, input longint step,
                                         input longint origin);
    longint p;
    p = idx * step;
    if (p > COORD_CAP) p = COORD_CAP;
    return q_sat(p + origin);
  endfunction

  function automatic mec_pkg::iter_t predict_escape_count(
      input logic [mec_pkg::IDX_W-1:0] col, input logic [mec_pkg::IDX_W-1:0] row);
    longint cr, ci, yy, s, xs, qv, lhs, zr, zi, a, b, nr, ni, n, lim;
    cr  = pixel_coord(longint'(col), longint'(step_re_cfg), RE_ORIGIN);
    ci  = pixel_coord(longint'(row), longint'(step_im_cfg), IM_ORIGIN);
    lim = longint'(max_iter_cfg);
    yy  = q_mul(ci, ci);
    // quarter-radius discs around 0 and -1
    if (q_mul(cr, cr) + yy < DISC_R2) return max_iter_cfg;
    s = q_sat(cr + UNIT);
    if (q_mul(s, s) + yy < DISC_R2) return max_iter_cfg;
    // main cardioid, multiply-only form, only for -0.75 < Re c < 0.5
    if (cr > -((3 * UNIT) >>> 2) && cr < (UNIT >>> 1)) begin
      xs  = q_sat(cr - (UNIT >>> 2));
      qv  = q_sat(q_mul(xs, xs) + yy);
      lhs = q_mul(qv, q_sat(qv + xs));
      if (lhs < (yy >>> 2)) return max_iter_cfg;
    end
    zr = 0;
    zi = 0;
    n  = 0;
    while (n < lim) begin
      a = q_mul(zr, zr);
      b = q_mul(zi, zi);
      if (a + b >= ESCAPE_R2) break;
      nr = q_sat(a - b + cr);
      ni = q_sat(2 * q_mul(zr, zi) + ci);
      zr = nr;
      zi = ni;
      n++;
    end
    return mec_pkg::iter_t'(n);
  endfunction

  always @(posedge clk) begin : monitor
    pixel_count_t head;
    if (!rst_n) begin
      max_iter_cfg = 25'd524288;
      step_re_cfg  = 30'd1008054;
      step_im_cfg  = 30'd1008054;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mec_pkg::CFG_MAX_ITER: max_iter_cfg = cfg_wdata[mec_pkg::ITER_W-1:0];
          mec_pkg::CFG_STEP_X:   step_re_cfg  = cfg_wdata[mec_pkg::STEP_W-1:0];
          mec_pkg::CFG_STEP_Y:   step_im_cfg  = cfg_wdata[mec_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      // result beat is checked before a start beat in the same cycle is queued
      if (out_valid) begin
        if (expected_counts.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result beat, iteration count %0d", $realtime,
                     out_iteration_count);
        end else begin
          head = expected_counts.pop_front();
          checked_count++;
          if (out_iteration_count !== head.count) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: pixel (%0d,%0d) iteration count expected %0d, got %0d",
                       $realtime, head.col, head.row, head.count, out_iteration_count);
          end
        end
      end
      if (start && !busy) begin
        head.col   = in_column;
        head.row   = in_row;
        head.count = predict_escape_count(in_column, in_row);
        if (head.count == max_iter_cfg) held_count++;
        expected_counts.push_back(head);
      end
    end
    pending_count = expected_counts.size();
  end

endmodule

// File: sim/mandelbrot_escape_iterations_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the escape-time core: clock, reset, pixel and register stimulus, verdict.
module mandelbrot_escape_iterations_core_tb;

  localparam int          RANDOM_PHASES = 9;
  localparam int          PHASE_ITEMS   = 100;
  localparam longint      CYCLE_LIMIT   = 2_000_000;
  localparam int          SETTLE_CYCLES = 30;
  localparam logic [29:0] STEP_256      = 30'd1048576;  // 1/256 per pixel
  localparam logic [29:0] STEP_FULL     = '1;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [mec_pkg::IDX_W-1:0]         in_column;
  logic [mec_pkg::IDX_W-1:0]         in_row;
  logic                              out_valid;
  logic [mec_pkg::ITER_W-1:0]        out_iteration_count;
  logic                              cfg_we;
  logic [mec_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [mec_pkg::CFG_W-1:0]         cfg_wdata;

  int          error_count;
  int          pending_count;
  int          checked_count;
  int          held_count;
  int          items_sent;
  int          settings_applied;
  int          burst_left;
  int          width;
  int          height;
  int          mode;
  logic [29:0] limit_sel;
  logic [29:0] step_re;
  logic [29:0] step_im;
  longint      cycles = 0;

  mandelbrot_escape_iterations_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  mandelbrot_escape_iterations_checker i_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .error_count         (error_count),
    .pending_count       (pending_count),
    .checked_count       (checked_count),
    .held_count          (held_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d counts still pending", cycles, pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // drop start and wait until every queued pixel has returned its count
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [29:0] max_iter, input logic [29:0] sx,
                                input logic [29:0] sy);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= mec_pkg::CFG_MAX_ITER;
    cfg_wdata <= max_iter;
    @(negedge clk);
    cfg_index <= mec_pkg::CFG_STEP_X;
    cfg_wdata <= sx;
    @(negedge clk);
    cfg_index <= mec_pkg::CFG_STEP_Y;
    cfg_wdata <= sy;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // one start beat; start stays high into the next pixel unless a gap follows
  task automatic send_pixel(input logic [mec_pkg::IDX_W-1:0] col,
                            input logic [mec_pkg::IDX_W-1:0] row);
    @(negedge clk);
    start     <= 1'b1;
    in_column <= col;
    in_row    <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_column  = '0;
    in_row     = '0;
    cfg_we     = 1'b0;
    cfg_index  = mec_pkg::CFG_MAX_ITER;
    cfg_wdata  = '0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: image corners, left edge, both discs, a fast escape
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 300);
    send_pixel(533, 300);
    send_pixel(266, 300);
    send_pixel(1023, 300);

    // top limit; only points that are caught early or escape fast
    apply_settings(30'd16777216, STEP_256, STEP_256);
    send_pixel(512, 288);
    send_pixel(256, 288);
    send_pixel(358, 365);
    send_pixel(0, 288);
    send_pixel(640, 288);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);

    // zero limit answers zero everywhere, pre-checks included
    apply_settings(30'd0, STEP_256, STEP_256);
    send_pixel(512, 288);
    send_pixel(358, 365);
    send_pixel(4095, 4095);

    // step extremes
    apply_settings(30'd40, STEP_FULL, 30'd0);
    send_pixel(0, 0);
    send_pixel(1, 4095);
    send_pixel(4095, 4095);
    apply_settings(30'd40, 30'd0, 30'd1);
    send_pixel(4095, 4095);
    send_pixel(2048, 1);

    // cusp at 0.25, left end of the cardioid window, disc edge at -0.25
    apply_settings(30'd1000, STEP_256, STEP_256);
    send_pixel(576, 288);
    send_pixel(320, 288);
    send_pixel(448, 288);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       limit_sel = 30'd1;
        1, 2:    limit_sel = 30'($urandom_range(2, 16));
        default: limit_sel = 30'($urandom_range(17, 255));
      endcase
      mode   = $urandom_range(0, 5);
      width  = $urandom_range(2, 4096);
      height = $urandom_range(2, 4096);
      if (mode == 0) begin
        step_re = 30'($urandom_range(0, 32'h3fff_ffff));
        step_im = 30'($urandom_range(0, 32'h3fff_ffff));
      end else if (mode == 1) begin
        step_re = ($urandom_range(0, 2) == 0) ? 30'd0 :
                  ($urandom_range(0, 1) == 0) ? 30'd1 : STEP_FULL;
        step_im = ($urandom_range(0, 2) == 0) ? 30'd0 :
                  ($urandom_range(0, 1) == 0) ? 30'd1 : STEP_FULL;
      end else begin
        // image view: 3.0 across the width, 2.25 down the height
        step_re = 30'((64'd3 << 28) / (width - 1));
        step_im = 30'((64'd9 << 26) / (height - 1));
      end
      apply_settings(limit_sel, step_re, step_im);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (mode >= 2 && $urandom_range(0, 6) != 0)
          send_pixel(12'($urandom_range(0, width - 1)), 12'($urandom_range(0, height - 1)));
        else
          send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d pixels under %0d register settings, limits from 0 to 2^24.",
             items_sent, settings_applied);
    $display("%0d counts compared: %0d escaped, %0d held at the iteration limit.",
             checked_count, checked_count - held_count, held_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
